// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file kth_checker.sv.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset disables.
`define KTH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disables.
`define KTH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/kth_pkg.sv -----
// Package for the keyed top-K hotspot table: sizes, codes, payload types
// and the command/status structs between controller and datapath.
`timescale 1ns / 1ps

package kth_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [31:0] SCORE_ONE     = 32'd65536;
    localparam logic [30:0] TRACKED_RESET = 31'd2318;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_RAISED   = 3'd1,
        ST_KEPT     = 3'd2,
        ST_APPENDED = 3'd3,
        ST_REPLACED = 3'd4,
        ST_REJECTED = 3'd5,
        ST_CLEARED  = 3'd6,
        ST_READ     = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        WS_ITEM,
        WS_RDATA,
        WS_CUR
    } t_wsel;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] item_key;
        logic [30:0]        item_node;
        logic [31:0]        item_score;
        logic [6:0]         read_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        read_ok;
        logic [30:0] out_key;
        logic [30:0] out_node;
        logic [31:0] out_score;
        logic [7:0]  entry_count;
        logic [30:0] tracked_best_node;
        logic [31:0] tracked_best_score;
    } t_out_item;

    typedef struct packed {
        logic [30:0] key;
        logic [30:0] node;
        logic [31:0] score;
    } t_entry;

    typedef struct packed {
        logic             load_item;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_wsel            wr_sel;
        logic             cur_load;
        logic             min_upd;
        logic             min_first;
        logic [IDX_W-1:0] min_idx;
        logic             cnt_clr;
        logic             cnt_inc;
        logic             trk_clr;
        logic             trk_upd;
        logic             out_load;
        t_status          out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0]       cmd;
        logic             ignore;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] rd_idx;
        logic             key_match;
        logic             new_gt_rd;
        logic             cur_lt_rd;
        logic             new_gt_min;
        logic [IDX_W-1:0] imin;
        logic             out_free;
    } t_dp_stat;

endpackage

// ----- hdl/kth_dpath.sv -----
// Datapath of the hotspot table: entry memory, latched item, sort and
// minimum registers, count, tracked record and result register. Uses kth_pkg.
`timescale 1ns / 1ps

module kth_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kth_pkg::t_in_item  i_in_data,
    input  logic [30:0]        i_tracked_key,
    input  kth_pkg::t_dp_cmd   i_cmd,
    output kth_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kth_pkg::t_out_item o_out_data
);

    kth_pkg::t_entry mem [kth_pkg::CAPACITY];

    kth_pkg::t_in_item  r_item;
    kth_pkg::t_entry    r_rdata;
    kth_pkg::t_entry    r_cur;
    logic [31:0]        r_min_score;
    logic [kth_pkg::IDX_W-1:0] r_imin;
    logic [kth_pkg::CNT_W-1:0] r_count;
    logic [30:0]        r_trk_node;
    logic [31:0]        r_trk_score;
    logic               r_ov;
    kth_pkg::t_out_item r_out;

    kth_pkg::t_entry item_entry;
    kth_pkg::t_entry wdata;
    logic            rd_hit;
    logic            read_hit;
    logic            out_free;

    assign item_entry = '{key: r_item.item_key[30:0], node: r_item.item_node,
                          score: r_item.item_score};

    always_comb begin
        unique case (i_cmd.wr_sel)
            kth_pkg::WS_ITEM:  wdata = item_entry;
            kth_pkg::WS_RDATA: wdata = r_rdata;
            kth_pkg::WS_CUR:   wdata = r_cur;
            default:           wdata = item_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_cmd.rd_addr];
        end
    end

    assign rd_hit   = 32'(r_item.read_index) < 32'(r_count);
    assign read_hit = (i_cmd.out_status == kth_pkg::ST_READ) && rd_hit;
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        o_stat.cmd        = r_item.cmd;
        o_stat.ignore     = r_item.item_key[31] || (r_item.item_score <= kth_pkg::SCORE_ONE);
        o_stat.count      = r_count;
        o_stat.rd_idx     = kth_pkg::IDX_W'(r_item.read_index);
        o_stat.key_match  = r_rdata.key == r_item.item_key[30:0];
        o_stat.new_gt_rd  = r_item.item_score > r_rdata.score;
        o_stat.cur_lt_rd  = r_cur.score < r_rdata.score;
        o_stat.new_gt_min = r_item.item_score > r_min_score;
        o_stat.imin       = r_imin;
        o_stat.out_free   = out_free;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.cur_load) begin
            r_cur <= r_rdata;
        end
        if (i_cmd.min_upd && (i_cmd.min_first || r_rdata.score < r_min_score)) begin
            r_min_score <= r_rdata.score;
            r_imin      <= i_cmd.min_idx;
        end
        if (i_cmd.out_load) begin
            r_out.status             <= i_cmd.out_status;
            r_out.read_ok            <= read_hit;
            r_out.out_key            <= read_hit ? r_rdata.key : '0;
            r_out.out_node           <= read_hit ? r_rdata.node : '0;
            r_out.out_score          <= read_hit ? r_rdata.score : '0;
            r_out.entry_count        <= 8'(r_count);
            r_out.tracked_best_node  <= r_trk_node;
            r_out.tracked_best_score <= r_trk_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_trk_node  <= '0;
            r_trk_score <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.trk_clr) begin
                r_trk_node  <= '0;
                r_trk_score <= '0;
            end else if (i_cmd.trk_upd && r_item.item_key[30:0] == i_tracked_key
                         && r_item.item_score > r_trk_score) begin
                r_trk_node  <= r_item.item_node;
                r_trk_score <= r_item.item_score;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/kth_ctrl.sv -----
// Controller of the hotspot table: sequences clear, read, scan, append shift,
// replace and exchange sort over the entry memory. Uses kth_pkg.
`timescale 1ns / 1ps

module kth_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kth_pkg::t_dp_stat i_stat,
    output kth_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SC_RD,
        S_SC_CMP,
        S_AP_RD,
        S_AP_CMP,
        S_FULL,
        S_SO_RDI,
        S_SO_LDI,
        S_SO_RDK,
        S_SO_CMP,
        S_SO_WRI,
        S_FIN
    } t_state;

    localparam logic [kth_pkg::IDX_W-1:0] LAST = kth_pkg::IDX_W'(kth_pkg::CAPACITY - 1);
    localparam logic [kth_pkg::IDX_W-1:0] PEN  = kth_pkg::IDX_W'(kth_pkg::CAPACITY - 2);

    t_state                    r_state, n_state;
    logic [kth_pkg::IDX_W-1:0] r_i, n_i;
    logic [kth_pkg::IDX_W-1:0] r_k, n_k;
    kth_pkg::t_status          r_status, n_status;

    logic [kth_pkg::CNT_W-1:0] last_held;

    assign last_held  = i_stat.count - 1'b1;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_k      = r_k;
        n_status = r_status;
        o_cmd            = '0;
        o_cmd.wr_sel     = kth_pkg::WS_ITEM;
        o_cmd.out_status = r_status;
        o_cmd.min_idx    = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                priority if (i_stat.cmd == kth_pkg::CMD_CLEAR) begin
                    o_cmd.cnt_clr = 1'b1;
                    o_cmd.trk_clr = 1'b1;
                    n_status = kth_pkg::ST_CLEARED;
                    n_state  = S_FIN;
                end else if (i_stat.cmd == kth_pkg::CMD_READ) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = i_stat.rd_idx;
                    n_status = kth_pkg::ST_READ;
                    n_state  = S_FIN;
                end else if (i_stat.cmd == kth_pkg::CMD_INSERT && !i_stat.ignore) begin
                    o_cmd.trk_upd = 1'b1;
                    n_k = '0;
                    if (i_stat.count == '0) begin
                        o_cmd.cnt_inc = 1'b1;
                        n_state = S_AP_RD;
                    end else begin
                        n_state = S_SC_RD;
                    end
                end else begin
                    n_status = kth_pkg::ST_IGNORED;
                    n_state  = S_FIN;
                end
            end
            S_SC_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_k;
                n_state = S_SC_CMP;
            end
            S_SC_CMP: begin
                o_cmd.min_upd   = 1'b1;
                o_cmd.min_first = r_k == '0;
                if (i_stat.key_match) begin
                    if (i_stat.new_gt_rd) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wr_addr = r_k;
                        n_status = kth_pkg::ST_RAISED;
                    end else begin
                        n_status = kth_pkg::ST_KEPT;
                    end
                    n_state = S_FIN;
                end else if (kth_pkg::CNT_W'(r_k) == last_held) begin
                    if (32'(i_stat.count) < kth_pkg::CAPACITY) begin
                        // new key, room left: shift in from the tail
                        o_cmd.cnt_inc = 1'b1;
                        n_k     = kth_pkg::IDX_W'(i_stat.count);
                        n_state = S_AP_RD;
                    end else begin
                        n_state = S_FULL;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SC_RD;
                end
            end
            S_AP_RD: begin
                if (r_k == '0) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = r_k;
                    n_status = kth_pkg::ST_APPENDED;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = r_k - 1'b1;
                    n_state = S_AP_CMP;
                end
            end
            S_AP_CMP: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_k;
                if (i_stat.new_gt_rd) begin
                    o_cmd.wr_sel = kth_pkg::WS_RDATA;
                    n_k     = r_k - 1'b1;
                    n_state = S_AP_RD;
                end else begin
                    n_status = kth_pkg::ST_APPENDED;
                    n_state  = S_FIN;
                end
            end
            S_FULL: begin
                if (i_stat.new_gt_min) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = i_stat.imin;
                    n_i     = '0;
                    n_state = S_SO_RDI;
                end else begin
                    n_status = kth_pkg::ST_REJECTED;
                    n_state  = S_FIN;
                end
            end
            S_SO_RDI: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_i;
                n_state = S_SO_LDI;
            end
            S_SO_LDI: begin
                o_cmd.cur_load = 1'b1;
                n_k     = r_i + 1'b1;
                n_state = S_SO_RDK;
            end
            S_SO_RDK: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_k;
                n_state = S_SO_CMP;
            end
            S_SO_CMP: begin
                // swap: held entry goes to k, the larger one is carried on
                if (i_stat.cur_lt_rd) begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_addr  = r_k;
                    o_cmd.wr_sel   = kth_pkg::WS_CUR;
                    o_cmd.cur_load = 1'b1;
                end
                if (r_k == LAST) begin
                    n_state = S_SO_WRI;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SO_RDK;
                end
            end
            S_SO_WRI: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = r_i;
                o_cmd.wr_sel  = kth_pkg::WS_CUR;
                if (r_i == PEN) begin
                    n_status = kth_pkg::ST_REPLACED;
                    n_state  = S_FIN;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SO_RDI;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_k      <= '0;
            r_status <= kth_pkg::ST_IGNORED;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_k      <= n_k;
            r_status <= n_status;
        end
    end

endmodule

// ----- hdl/keyed_top_k_hotspot_table.sv -----
// Keyed top-K hotspot table, top level: APB register, controller and
// datapath. Uses kth_pkg, kth_ctrl, kth_dpath.
//
// One item at a time; a result waits in an output register while the next
// item is taken. All work goes through one entry memory with one write
// and one registered read a cycle: clear, read and ignored items go
// straight to the result; an insert of a held key scans up to the match;
// a new key with room is shifted in from the tail after the scan; a full
// table is scanned, then rejects the item or replaces the minimum and
// re-sorts by exchange, the re-sort dominating. A stalled result adds
// its stall on top. tracked_key sits at addresses 0 to 3 (paddr[2] low).
`timescale 1ns / 1ps

module keyed_top_k_hotspot_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kth_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output kth_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [30:0]       r_tracked_key;
    kth_pkg::t_dp_cmd  dp_cmd;
    kth_pkg::t_dp_stat dp_stat;
    kth_pkg::t_in_item in_data;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked_key <= kth_pkg::TRACKED_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_tracked_key <= pwdata[30:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {1'b0, r_tracked_key} : 32'd0;

    assign in_data = i_in_data;

    kth_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    kth_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (in_data),
        .i_tracked_key (r_tracked_key),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule

// ----- hdl/kth_checker.sv -----
// Port-level checks for the hotspot table, bound to the top level.
// Uses kth_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kth_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input kth_pkg::t_out_item o_out_data
);

    `KTH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid, "result dropped while stalled")
    `KTH_ASSERT_NOW(a_ok_is_read, i_clk, i_rst_n, o_out_valid && o_out_data.read_ok,
        o_out_data.status == kth_pkg::ST_READ, "read_ok on a non-read")
    `KTH_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.read_ok,
        o_out_data.out_key == '0 && o_out_data.out_score == '0,
        "entry fields set without a hit")
    `KTH_ASSERT_NOW(a_clear_empty, i_clk, i_rst_n,
        o_out_valid && o_out_data.status == kth_pkg::ST_CLEARED,
        o_out_data.entry_count == '0 && o_out_data.tracked_best_score == '0,
        "clear left state")

endmodule

bind keyed_top_k_hotspot_table kth_port_checker u_kth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
